FILE: rtl/core/extalloc_pkg.sv
// ----------------------------------------------------------------------------
// extalloc_pkg: shared types and constants
// Table geometry, field widths, operation and status codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package extalloc_pkg;

   // table geometry and widths
   localparam int MAX_EXTENTS = 64;
   localparam int UNIT_BITS   = 16;
   localparam int ID_BITS     = 8;
   localparam int IDX_BITS    = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int CNT_BITS    = $clog2(MAX_EXTENTS + 1);
   localparam int ENTRY_BITS  = ID_BITS + 2 * UNIT_BITS;

   // port field widths
   localparam int OPC_BITS   = 2;
   localparam int FID_BITS   = 8;
   localparam int FSIZE_BITS = 16;
   localparam int DISK_BITS  = 16;
   localparam int STAT_BITS  = 2;
   localparam int START_BITS = 16;

   typedef logic [UNIT_BITS-1:0]  unit_type;
   typedef logic [ID_BITS-1:0]    id_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [START_BITS-1:0] start_type;

   typedef struct packed {
      id_type   id;
      unit_type start;
      unit_type stop;
   } entry_type;

   localparam unit_type DISK_RESET = unit_type'(65535);

   typedef enum logic [OPC_BITS-1:0] {
      OP_WRITE   = 2'd0,
      OP_SHOW    = 2'd1,
      OP_DELETE  = 2'd2,
      OP_COMPACT = 2'd3
   } op_type;

   typedef enum logic [STAT_BITS-1:0] {
      ST_OK         = 2'd0,
      ST_NAME_ERR   = 2'd1,
      ST_DISK_FULL  = 2'd2,
      ST_TABLE_FULL = 2'd3
   } status_type;

   // what the current pass over the table does
   typedef enum logic [2:0] {
      MODE_SCAN,
      MODE_APPLY,
      MODE_SHOW,
      MODE_DELETE,
      MODE_COMPACT
   } mode_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_INIT,
      CMD_READ,
      CMD_EVAL,
      CMD_COPY,
      CMD_FINISH
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_READ,
      S_EVAL,
      S_COPY,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic empty;       // table holds no entry
      logic last_entry;  // current index is the final entry
      logic hold;        // result register full and stalled
      logic need_copy;   // an extent was inserted, source entry still to copy
      logic again;       // a second pass follows
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/extalloc_ram.sv
// ----------------------------------------------------------------------------
// extalloc_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module extalloc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/core/extalloc_ctrl.sv
// ----------------------------------------------------------------------------
// extalloc_ctrl: command sequencer
// Walks the extent table one entry at a time and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module extalloc_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire extalloc_pkg::dp_status_type stat,
   output extalloc_pkg::cmd_type            cmd
);

   extalloc_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         extalloc_pkg::S_IDLE: begin
            if (req_valid) state_in = extalloc_pkg::S_INIT;
         end
         extalloc_pkg::S_INIT: begin
            state_in = stat.empty ? extalloc_pkg::S_FINISH : extalloc_pkg::S_READ;
         end
         extalloc_pkg::S_READ: begin
            state_in = extalloc_pkg::S_EVAL;
         end
         extalloc_pkg::S_EVAL: begin
            if (stat.hold) state_in = extalloc_pkg::S_EVAL;
            else if (stat.need_copy) state_in = extalloc_pkg::S_COPY;
            else if (stat.last_entry) state_in = extalloc_pkg::S_FINISH;
            else state_in = extalloc_pkg::S_READ;
         end
         extalloc_pkg::S_COPY: begin
            state_in = stat.last_entry ? extalloc_pkg::S_FINISH : extalloc_pkg::S_READ;
         end
         extalloc_pkg::S_FINISH: begin
            if (stat.hold) state_in = extalloc_pkg::S_FINISH;
            else if (stat.again) state_in = extalloc_pkg::S_INIT;
            else state_in = extalloc_pkg::S_IDLE;
         end
         default: state_in = extalloc_pkg::S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = extalloc_pkg::CMD_NONE;
      case (state_ff)
         extalloc_pkg::S_IDLE:   cmd = req_valid ? extalloc_pkg::CMD_ACCEPT
                                                 : extalloc_pkg::CMD_NONE;
         extalloc_pkg::S_INIT:   cmd = extalloc_pkg::CMD_INIT;
         extalloc_pkg::S_READ:   cmd = extalloc_pkg::CMD_READ;
         extalloc_pkg::S_EVAL:   cmd = extalloc_pkg::CMD_EVAL;
         extalloc_pkg::S_COPY:   cmd = extalloc_pkg::CMD_COPY;
         extalloc_pkg::S_FINISH: cmd = extalloc_pkg::CMD_FINISH;
         default:                cmd = extalloc_pkg::CMD_NONE;
      endcase
   end

   assign req_stall = (state_ff != extalloc_pkg::S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= extalloc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/extalloc_dp.sv
// ----------------------------------------------------------------------------
// extalloc_dp: extent table datapath
// Two table banks used ping-pong: a pass that rebuilds the table reads the
// live bank and writes into the other, which becomes live at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module extalloc_dp (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire extalloc_pkg::cmd_type                     cmd,
   output extalloc_pkg::dp_status_type                    stat,
   input  wire logic [extalloc_pkg::OPC_BITS-1:0]         req_opcode,
   input  wire logic [extalloc_pkg::FID_BITS-1:0]         req_file_id,
   input  wire logic [extalloc_pkg::FSIZE_BITS-1:0]       req_file_size,
   input  wire logic                                      csr_we,
   input  wire logic [extalloc_pkg::DISK_BITS-1:0]        csr_wdata,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic [extalloc_pkg::STAT_BITS-1:0]             rsp_status,
   output logic [extalloc_pkg::START_BITS-1:0]            rsp_extent_start,
   output logic                                           rsp_last
);

   // state
   extalloc_pkg::mode_type   mode_ff, mode_in;
   extalloc_pkg::id_type     id_ff, id_in;
   extalloc_pkg::unit_type   size_ff, size_in;
   extalloc_pkg::unit_type   disk_ff, disk_in;
   extalloc_pkg::unit_type   free_ff, free_in;
   extalloc_pkg::cnt_type    count_ff, count_in;
   logic                     sel_ff, sel_in;
   extalloc_pkg::idx_type    i_ff, i_in;
   extalloc_pkg::cnt_type    k_ff, k_in;
   extalloc_pkg::unit_type   prev_ff, prev_in;
   extalloc_pkg::unit_type   rem_ff, rem_in;
   logic                     done_ff, done_in;
   logic                     sdone_ff, sdone_in;
   logic                     present_ff, present_in;
   extalloc_pkg::cnt_type    used_ff, used_in;
   logic                     split_ff, split_in;
   logic                     pend_v_ff, pend_v_in;
   extalloc_pkg::unit_type   pend_ff, pend_in;
   extalloc_pkg::entry_type  last_ff, last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   extalloc_pkg::status_type rsp_status_ff, rsp_status_in;
   extalloc_pkg::unit_type   rsp_start_ff, rsp_start_in;
   logic                     rsp_last_ff, rsp_last_in;

   // table banks
   logic                    ram_wen;
   extalloc_pkg::cnt_type   ram_wptr;
   extalloc_pkg::entry_type ram_wdata;
   logic [extalloc_pkg::ENTRY_BITS-1:0] rdata0, rdata1;

   extalloc_ram #(
      .WIDTH (extalloc_pkg::ENTRY_BITS),
      .DEPTH (extalloc_pkg::MAX_EXTENTS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (ram_wen && sel_ff),
      .wr_addr (ram_wptr[extalloc_pkg::IDX_BITS-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (i_ff),
      .rd_data (rdata0)
   );

   extalloc_ram #(
      .WIDTH (extalloc_pkg::ENTRY_BITS),
      .DEPTH (extalloc_pkg::MAX_EXTENTS)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (ram_wen && !sel_ff),
      .wr_addr (ram_wptr[extalloc_pkg::IDX_BITS-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (i_ff),
      .rd_data (rdata1)
   );

   // current source entry and derived values
   extalloc_pkg::entry_type  ent;
   extalloc_pkg::unit_type   gap;
   extalloc_pkg::unit_type   tail;
   extalloc_pkg::unit_type   ent_len;
   extalloc_pkg::unit_type   cmp_stop;
   logic                     match;
   logic                     single_fit;
   extalloc_pkg::cnt_type    need;
   extalloc_pkg::cnt_type    room;
   extalloc_pkg::status_type scan_status;

   always_comb begin
      ent      = extalloc_pkg::entry_type'(sel_ff ? rdata1 : rdata0);
      gap      = (ent.start > prev_ff) ? ent.start - prev_ff : '0;
      tail     = (disk_ff > prev_ff) ? disk_ff - prev_ff : '0;
      ent_len  = (ent.stop > ent.start) ? ent.stop - ent.start : '0;
      cmp_stop = (ent.stop >= gap) ? ent.stop - gap : '0;
      match    = (ent.id == id_ff);
      single_fit = sdone_ff || (tail >= size_ff);
      need     = single_fit ? extalloc_pkg::cnt_type'(1)
                            : extalloc_pkg::cnt_type'(used_ff + (done_ff ? 1'b0 : 1'b1));
      room     = extalloc_pkg::cnt_type'(extalloc_pkg::MAX_EXTENTS) - count_ff;
      if (present_ff) scan_status = extalloc_pkg::ST_NAME_ERR;
      else if (free_ff < size_ff) scan_status = extalloc_pkg::ST_DISK_FULL;
      else if (need > room) scan_status = extalloc_pkg::ST_TABLE_FULL;
      else scan_status = extalloc_pkg::ST_OK;
   end

   // result to load this cycle
   logic                     emit;
   extalloc_pkg::status_type emit_status;
   extalloc_pkg::unit_type   emit_start;
   logic                     emit_last;
   logic                     hold;

   always_comb begin
      emit        = 1'b0;
      emit_status = extalloc_pkg::ST_OK;
      emit_start  = '0;
      emit_last   = 1'b0;
      if (cmd == extalloc_pkg::CMD_EVAL) begin
         if (mode_ff == extalloc_pkg::MODE_SHOW && match && pend_v_ff) begin
            emit       = 1'b1;
            emit_start = pend_ff;
         end
      end else if (cmd == extalloc_pkg::CMD_FINISH) begin
         emit_last = 1'b1;
         case (mode_ff)
            extalloc_pkg::MODE_SCAN: begin
               emit        = (scan_status != extalloc_pkg::ST_OK);
               emit_status = scan_status;
            end
            extalloc_pkg::MODE_SHOW: begin
               emit = 1'b1;
               if (pend_v_ff) emit_start = pend_ff;
               else emit_status = extalloc_pkg::ST_NAME_ERR;
            end
            extalloc_pkg::MODE_DELETE: begin
               emit = 1'b1;
               if (!present_ff) emit_status = extalloc_pkg::ST_NAME_ERR;
            end
            default: emit = 1'b1;
         endcase
      end
      hold = emit && rsp_valid_ff && rsp_stall;
   end

   // next-state logic
   logic need_copy;
   logic again;

   always_comb begin
      mode_in    = mode_ff;
      id_in      = id_ff;
      size_in    = size_ff;
      disk_in    = disk_ff;
      free_in    = free_ff;
      count_in   = count_ff;
      sel_in     = sel_ff;
      i_in       = i_ff;
      k_in       = k_ff;
      prev_in    = prev_ff;
      rem_in     = rem_ff;
      done_in    = done_ff;
      sdone_in   = sdone_ff;
      present_in = present_ff;
      used_in    = used_ff;
      split_in   = split_ff;
      pend_v_in  = pend_v_ff;
      pend_in    = pend_ff;
      last_in    = last_ff;
      ram_wen    = 1'b0;
      ram_wptr   = k_ff;
      ram_wdata  = ent;
      need_copy  = 1'b0;
      again      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_last_in   = rsp_last_ff;

      if (!hold) begin
         case (cmd)
            extalloc_pkg::CMD_ACCEPT: begin
               id_in   = extalloc_pkg::id_type'(req_file_id);
               size_in = extalloc_pkg::unit_type'(req_file_size);
               case (extalloc_pkg::op_type'(req_opcode))
                  extalloc_pkg::OP_WRITE:  mode_in = extalloc_pkg::MODE_SCAN;
                  extalloc_pkg::OP_SHOW:   mode_in = extalloc_pkg::MODE_SHOW;
                  extalloc_pkg::OP_DELETE: mode_in = extalloc_pkg::MODE_DELETE;
                  default:                 mode_in = extalloc_pkg::MODE_COMPACT;
               endcase
            end
            extalloc_pkg::CMD_INIT: begin
               i_in       = '0;
               k_in       = '0;
               prev_in    = '0;
               rem_in     = size_ff;
               done_in    = 1'b0;
               sdone_in   = 1'b0;
               present_in = 1'b0;
               used_in    = '0;
               pend_v_in  = 1'b0;
            end
            extalloc_pkg::CMD_EVAL: begin
               case (mode_ff)
                  // plan pass: presence, single-gap fit and split entry count
                  extalloc_pkg::MODE_SCAN: begin
                     if (match) present_in = 1'b1;
                     if (!sdone_ff && gap >= size_ff) sdone_in = 1'b1;
                     if (!done_ff) begin
                        if (gap >= rem_ff) begin
                           used_in = used_ff + 1'b1;
                           done_in = 1'b1;
                        end else if (gap != '0) begin
                           used_in = used_ff + 1'b1;
                           rem_in  = rem_ff - gap;
                        end
                     end
                     prev_in = ent.stop;
                     i_in    = i_ff + 1'b1;
                  end
                  // placement pass: insert new extent ahead of the entry
                  extalloc_pkg::MODE_APPLY: begin
                     if (!done_ff && gap >= rem_ff) begin
                        ram_wen   = 1'b1;
                        ram_wdata = '{id: id_ff, start: prev_ff, stop: prev_ff + rem_ff};
                        k_in      = k_ff + 1'b1;
                        done_in   = 1'b1;
                        need_copy = 1'b1;
                     end else if (!done_ff && split_ff && gap != '0) begin
                        ram_wen   = 1'b1;
                        ram_wdata = '{id: id_ff, start: prev_ff, stop: ent.start};
                        k_in      = k_ff + 1'b1;
                        rem_in    = rem_ff - gap;
                        need_copy = 1'b1;
                     end else begin
                        ram_wen = 1'b1;
                        k_in    = k_ff + 1'b1;
                        prev_in = ent.stop;
                        i_in    = i_ff + 1'b1;
                     end
                  end
                  // one result behind, so the final one carries last
                  extalloc_pkg::MODE_SHOW: begin
                     if (match) begin
                        pend_in   = ent.start;
                        pend_v_in = 1'b1;
                     end
                     i_in = i_ff + 1'b1;
                  end
                  extalloc_pkg::MODE_DELETE: begin
                     if (match) begin
                        present_in = 1'b1;
                        free_in    = free_ff + ent_len;
                     end else begin
                        ram_wen = 1'b1;
                        k_in    = k_ff + 1'b1;
                     end
                     i_in = i_ff + 1'b1;
                  end
                  // slide down; merge a moved extent into a same-id predecessor
                  default: begin
                     if (gap != '0) begin
                        if (k_ff != '0 && last_ff.id == ent.id) begin
                           ram_wen   = 1'b1;
                           ram_wptr  = k_ff - 1'b1;
                           ram_wdata = '{id: last_ff.id, start: last_ff.start, stop: cmp_stop};
                           last_in.stop = cmp_stop;
                        end else begin
                           ram_wen   = 1'b1;
                           ram_wdata = '{id: ent.id, start: prev_ff, stop: cmp_stop};
                           last_in   = '{id: ent.id, start: prev_ff, stop: cmp_stop};
                           k_in      = k_ff + 1'b1;
                        end
                        prev_in = cmp_stop;
                     end else begin
                        ram_wen = 1'b1;
                        last_in = ent;
                        k_in    = k_ff + 1'b1;
                        prev_in = ent.stop;
                     end
                     i_in = i_ff + 1'b1;
                  end
               endcase
            end
            extalloc_pkg::CMD_COPY: begin
               ram_wen = 1'b1;
               k_in    = k_ff + 1'b1;
               prev_in = ent.stop;
               i_in    = i_ff + 1'b1;
            end
            extalloc_pkg::CMD_FINISH: begin
               case (mode_ff)
                  extalloc_pkg::MODE_SCAN: begin
                     if (scan_status == extalloc_pkg::ST_OK) begin
                        free_in  = free_ff - size_ff;
                        split_in = !single_fit;
                        mode_in  = extalloc_pkg::MODE_APPLY;
                        again    = 1'b1;
                     end
                  end
                  // remainder or whole file after the last extent
                  extalloc_pkg::MODE_APPLY: begin
                     count_in = k_ff;
                     if (!done_ff && (split_ff || tail >= rem_ff)) begin
                        ram_wen   = 1'b1;
                        ram_wdata = '{id: id_ff, start: prev_ff, stop: prev_ff + rem_ff};
                        count_in  = k_ff + 1'b1;
                     end
                     sel_in = !sel_ff;
                  end
                  extalloc_pkg::MODE_SHOW: begin
                  end
                  default: begin
                     count_in = k_ff;
                     sel_in   = !sel_ff;
                  end
               endcase
            end
            default: begin
            end
         endcase

         if (emit) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = emit_status;
            rsp_start_in  = emit_start;
            rsp_last_in   = emit_last;
         end
      end

      // disk size write clears the table
      if (csr_we) begin
         disk_in  = extalloc_pkg::unit_type'(csr_wdata);
         free_in  = extalloc_pkg::unit_type'(csr_wdata);
         count_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         disk_ff      <= extalloc_pkg::DISK_RESET;
         free_ff      <= extalloc_pkg::DISK_RESET;
         count_ff     <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= extalloc_pkg::MODE_SHOW;
      end else begin
         disk_ff      <= disk_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      size_ff       <= size_in;
      i_ff          <= i_in;
      k_ff          <= k_in;
      prev_ff       <= prev_in;
      rem_ff        <= rem_in;
      done_ff       <= done_in;
      sdone_ff      <= sdone_in;
      present_ff    <= present_in;
      used_ff       <= used_in;
      split_ff      <= split_in;
      pend_v_ff     <= pend_v_in;
      pend_ff       <= pend_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign stat.empty      = (count_ff == '0);
   assign stat.last_entry = ((extalloc_pkg::cnt_type'(i_ff) + 1'b1) == count_ff);
   assign stat.hold       = hold;
   assign stat.need_copy  = need_copy;
   assign stat.again      = again;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_extent_start = extalloc_pkg::start_type'(rsp_start_ff);
   assign rsp_last         = rsp_last_ff;

   // checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= extalloc_pkg::cnt_type'(extalloc_pkg::MAX_EXTENTS))
      else $error("extent count beyond table depth");

   a_wptr_bound : assert property (@(posedge clock) disable iff (reset)
      ram_wen |-> (ram_wptr < extalloc_pkg::cnt_type'(extalloc_pkg::MAX_EXTENTS)))
      else $error("table write beyond depth");

   a_hold_keeps : assert property (@(posedge clock) disable iff (reset)
      hold |=> rsp_valid_ff)
      else $error("held result register emptied");

   a_show_final : assert property (@(posedge clock) disable iff (reset)
      (cmd == extalloc_pkg::CMD_FINISH && mode_ff == extalloc_pkg::MODE_SHOW && !hold)
      |=> (rsp_valid_ff && rsp_last_ff))
      else $error("show finished without final result");

endmodule

`default_nettype wire

FILE: rtl/core/extent_allocator_with_compaction.sv
// ----------------------------------------------------------------------------
// extent_allocator_with_compaction: first-fit extent allocator
// Sorted extent table with write, show, delete and compact commands.
// ----------------------------------------------------------------------------
// Each command walks the extent table one entry at a time through a
// registered-read table memory, reading each entry and then evaluating it;
// show, delete and compact make one pass. A write makes a planning pass (a
// write refused there ends after it) and, if accepted, a placement pass,
// which adds a copy step per extent inserted ahead of an existing entry.
// No new command is taken until the current one has finished. Show
// results leave one per matching extent and each waits on the result stall,
// which adds its stalled cycles to the command. A disk size write takes
// effect at once and empties the table; no clearing pass.
`default_nettype none

module extent_allocator_with_compaction (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [extalloc_pkg::OPC_BITS-1:0]   req_opcode,
   input  wire logic [extalloc_pkg::FID_BITS-1:0]   req_file_id,
   input  wire logic [extalloc_pkg::FSIZE_BITS-1:0] req_file_size,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [extalloc_pkg::STAT_BITS-1:0]       rsp_status,
   output logic [extalloc_pkg::START_BITS-1:0]      rsp_extent_start,
   output logic                                     rsp_last,
   input  wire logic                                csr_we,
   input  wire logic [extalloc_pkg::DISK_BITS-1:0]  csr_wdata
);

   extalloc_pkg::cmd_type       cmd;
   extalloc_pkg::dp_status_type stat;

   extalloc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   extalloc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_file_id      (req_file_id),
      .req_file_size    (req_file_size),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_extent_start (rsp_extent_start),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

FILE: tb/sv/extent_allocator_with_compaction_chk.sv
// ----------------------------------------------------------------------------
// extent_allocator_with_compaction_chk: prediction and checking
// Watches the request, result and register ports, keeps its own copy of the
// extent table, predicts every result of each accepted command and compares
// them in order with the results the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module extent_allocator_with_compaction_chk (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire logic [1:0]       req_opcode,
   input  wire logic [7:0]       req_file_id,
   input  wire logic [15:0]      req_file_size,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire logic [1:0]       rsp_status,
   input  wire logic [15:0]      rsp_extent_start,
   input  wire logic             rsp_last,
   input  wire logic             csr_we,
   input  wire logic [15:0]      csr_wdata,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      extalloc_pkg::status_type st;
      extalloc_pkg::unit_type   start;
      logic                     last;
   } result_type;

   typedef struct {
      extalloc_pkg::id_type   id;
      extalloc_pkg::unit_type start;
      extalloc_pkg::unit_type stop;
   } ext_type;

   ext_type                extents[$];
   extalloc_pkg::unit_type disk_units;
   extalloc_pkg::unit_type free_units;
   result_type             expected_results[$];

   function automatic bit id_known(extalloc_pkg::id_type id);
      foreach (extents[i])
         if (extents[i].id == id) return 1;
      return 0;
   endfunction

   // plans a placement; with apply set also rebuilds the table
   function automatic int place_file(extalloc_pkg::id_type id, extalloc_pkg::unit_type size,
                                     bit split, bit apply);
      ext_type rebuilt[$];
      ext_type e;
      int      used;
      int      rem;
      int      prev;
      int      gap;
      bit      done;
      used = 0; rem = int'(size); prev = 0; done = 0;
      foreach (extents[i]) begin
         if (!done) begin
            gap = (int'(extents[i].start) > prev) ? int'(extents[i].start) - prev : 0;
            if (gap >= rem) begin
               e.id = id; e.start = extalloc_pkg::unit_type'(prev);
               e.stop = extalloc_pkg::unit_type'(prev + rem);
               rebuilt = {rebuilt, e};
               used++;
               done = 1;
            end else if (split && gap != 0) begin
               e.id = id; e.start = extalloc_pkg::unit_type'(prev);
               e.stop = extents[i].start;
               rebuilt = {rebuilt, e};
               used++;
               rem -= gap;
            end
         end
         rebuilt = {rebuilt, extents[i]};
         prev = int'(extents[i].stop);
      end
      if (!done) begin
         gap = (int'(disk_units) > prev) ? int'(disk_units) - prev : 0;
         if (split || gap >= rem) begin
            e.id = id; e.start = extalloc_pkg::unit_type'(prev);
            e.stop = extalloc_pkg::unit_type'(prev + rem);
            rebuilt = {rebuilt, e};
            used++;
         end
      end
      if (apply) extents = rebuilt;
      return used;
   endfunction

   function automatic extalloc_pkg::status_type write_file(extalloc_pkg::id_type id,
                                                            extalloc_pkg::unit_type size);
      int need;
      bit split;
      if (id_known(id)) return extalloc_pkg::ST_NAME_ERR;
      if (free_units < size) return extalloc_pkg::ST_DISK_FULL;
      need = place_file(id, size, 0, 0);
      split = (need == 0);
      if (split) need = place_file(id, size, 1, 0);
      if (need > extalloc_pkg::MAX_EXTENTS - extents.size())
         return extalloc_pkg::ST_TABLE_FULL;
      free_units -= size;
      void'(place_file(id, size, split, 1));
      return extalloc_pkg::ST_OK;
   endfunction

   function automatic void delete_file(extalloc_pkg::id_type id);
      ext_type kept[$];
      foreach (extents[i])
         if (extents[i].id == id) begin
            if (extents[i].stop > extents[i].start)
               free_units += extents[i].stop - extents[i].start;
         end else kept = {kept, extents[i]};
      extents = kept;
   endfunction

   // slide down; merge a moved extent into a same-id predecessor
   function automatic void compact_disk();
      ext_type packed_q[$];
      ext_type e;
      int      prev;
      int      gap;
      prev = 0;
      foreach (extents[i]) begin
         e = extents[i];
         gap = (int'(e.start) > prev) ? int'(e.start) - prev : 0;
         if (gap > 0) begin
            e.start = extalloc_pkg::unit_type'(prev);
            e.stop = (int'(e.stop) >= gap) ? extalloc_pkg::unit_type'(int'(e.stop) - gap)
                                           : '0;
            if (packed_q.size() > 0 && packed_q[$].id == e.id) begin
               packed_q[$].stop = e.stop;
               prev = int'(e.stop);
               continue;
            end
         end
         packed_q = {packed_q, e};
         prev = int'(e.stop);
      end
      extents = packed_q;
   endfunction

   function automatic void predict_command(extalloc_pkg::op_type op, extalloc_pkg::id_type id,
                                           extalloc_pkg::unit_type size);
      result_type r;
      r.st = extalloc_pkg::ST_OK; r.start = '0; r.last = 1;
      case (op)
         extalloc_pkg::OP_WRITE: r.st = write_file(id, size);
         extalloc_pkg::OP_SHOW: begin
            if (!id_known(id)) r.st = extalloc_pkg::ST_NAME_ERR;
            else begin
               foreach (extents[i])
                  if (extents[i].id == id) begin
                     r.start = extents[i].start; r.last = 0;
                     expected_results = {expected_results, r};
                  end
               expected_results[$].last = 1;
               return;
            end
         end
         extalloc_pkg::OP_DELETE: begin
            if (!id_known(id)) r.st = extalloc_pkg::ST_NAME_ERR;
            else delete_file(id);
         end
         default: compact_disk();
      endcase
      expected_results = {expected_results, r};
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // watch all ports at each rising edge
   always @(posedge clock) begin
      result_type r;
      if (reset) begin
         extents.delete();
         expected_results.delete();
         disk_units = extalloc_pkg::DISK_RESET;
         free_units = extalloc_pkg::DISK_RESET;
         fail_count = 0;
      end else begin
         if (csr_we) begin
            disk_units = csr_wdata;
            free_units = csr_wdata;
            extents.delete();
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0)
               report("unexpected transfer, status", int'(rsp_status), 0);
            else begin
               r = expected_results.pop_front();
               if (rsp_status !== r.st)
                  report("status", int'(rsp_status), int'(r.st));
               if (rsp_extent_start !== r.start)
                  report("extent_start", int'(rsp_extent_start), int'(r.start));
               if (rsp_last !== r.last)
                  report("last", int'(rsp_last), int'(r.last));
            end
         end
         if (req_valid && !req_stall)
            predict_command(extalloc_pkg::op_type'(req_opcode), req_file_id, req_file_size);
      end
      pending = expected_results.size();
   end
endmodule

`default_nettype wire

FILE: tb/sv/extent_allocator_with_compaction_tb.sv
// ----------------------------------------------------------------------------
// extent_allocator_with_compaction_tb: testbench top
// Drives directed and random command sequences in bursts, stalls results on
// a pattern, changes the disk size between phases and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module extent_allocator_with_compaction_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [7:0]  req_file_id = '0;
   logic [15:0] req_file_size = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_extent_start;
   logic        rsp_last;
   logic        csr_we = 0;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending;
   int          cycles = 0;
   int          stall_mode = 0;

   localparam int CYCLE_LIMIT = 2_000_000;

   always #4 clock = ~clock;

   extent_allocator_with_compaction uut (.*);
   extent_allocator_with_compaction_chk chk (.*);

   // timeout guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result stall pattern: phases of none, light, heavy stalling
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= int'($urandom_range(0, 2));
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // one command transfer, then maybe a gap
   task automatic send(extalloc_pkg::op_type op, logic [7:0] id, logic [15:0] size);
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_file_id   <= id;
      req_file_size <= size;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_disk(logic [15:0] units);
      csr_we    <= 1'b1;
      csr_wdata <= units;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // random phase: small id pool so names collide, writes half the time
   task automatic random_phase(int count, int size_max, int id_max);
      int  pick;
      repeat (count) begin
         pick = int'($urandom_range(0, 9));
         if (pick < 5)
            send(extalloc_pkg::OP_WRITE, 8'($urandom_range(0, id_max)),
                 ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, size_max)));
         else if (pick < 7)
            send(extalloc_pkg::OP_SHOW, 8'($urandom_range(0, id_max)), 16'($urandom));
         else if (pick < 9)
            send(extalloc_pkg::OP_DELETE, 8'($urandom_range(0, id_max)), 16'($urandom));
         else send(extalloc_pkg::OP_COMPACT, 8'($urandom), 16'($urandom));
      end
      quiesce();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, every operation, name and disk-full errors
      send(extalloc_pkg::OP_COMPACT, 8'h00, 16'h0000);
      send(extalloc_pkg::OP_SHOW, 8'hFF, 16'hFFFF);
      send(extalloc_pkg::OP_DELETE, 8'h00, 16'h0000);
      send(extalloc_pkg::OP_WRITE, 8'h00, 16'h0000);
      send(extalloc_pkg::OP_WRITE, 8'hFF, 16'h0010);
      send(extalloc_pkg::OP_WRITE, 8'hFF, 16'h0001);
      send(extalloc_pkg::OP_WRITE, 8'h01, 16'hFFFF);
      send(extalloc_pkg::OP_WRITE, 8'h02, 16'h0020);
      send(extalloc_pkg::OP_WRITE, 8'h03, 16'h0005);
      send(extalloc_pkg::OP_DELETE, 8'hFF, 16'h0000);
      send(extalloc_pkg::OP_WRITE, 8'h04, 16'h0030);
      send(extalloc_pkg::OP_SHOW, 8'h04, 16'h0000);
      send(extalloc_pkg::OP_COMPACT, 8'h00, 16'h0000);
      send(extalloc_pkg::OP_SHOW, 8'h04, 16'h0000);
      send(extalloc_pkg::OP_SHOW, 8'h00, 16'h0000);
      quiesce();

      // tiny disk: fill it, then a disk-full write and a delete
      set_disk(16'd1);
      send(extalloc_pkg::OP_WRITE, 8'h10, 16'd1);
      send(extalloc_pkg::OP_WRITE, 8'h11, 16'd1);
      send(extalloc_pkg::OP_DELETE, 8'h10, 16'd0);
      quiesce();
      set_disk(16'd100);
      random_phase(120, 20, 15);

      // many tiny extents to fill the table
      set_disk(16'd200);
      for (int i = 0; i < 70; i++) send(extalloc_pkg::OP_WRITE, i[7:0], 16'd1);
      for (int i = 0; i < 70; i += 2) send(extalloc_pkg::OP_DELETE, i[7:0], 16'd0);
      send(extalloc_pkg::OP_WRITE, 8'hA0, 16'd60);
      send(extalloc_pkg::OP_SHOW, 8'hA0, 16'd0);
      quiesce();

      set_disk(16'hFFFF);
      random_phase(95, 16'hFFFF, 7);
      set_disk(16'd40);
      random_phase(120, 12, 31);

      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/extalloc_pkg.sv
rtl/core/extalloc_ram.sv
rtl/core/extalloc_ctrl.sv
rtl/core/extalloc_dp.sv
rtl/core/extent_allocator_with_compaction.sv
tb/sv/extent_allocator_with_compaction_chk.sv
tb/sv/extent_allocator_with_compaction_tb.sv
